>>> hw/rtl/segment_index_reference_merger_defines.svh
// ============================================================================
// Segment index reference merger - assertion macros
// Shared concurrent assertion forms used by the merger's modules.
// ============================================================================
`ifndef SEGMENT_INDEX_REFERENCE_MERGER_DEFINES_SVH
`define SEGMENT_INDEX_REFERENCE_MERGER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SIRM_ASSERT_IMPLY(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("merger assertion failed");

// Next-cycle implication, checked outside reset
`define SIRM_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("merger assertion failed");

`endif

>>> hw/rtl/sirm_pkg.sv
// ============================================================================
// Segment index reference merger - package
// Item types, queue entry type and shared constants.
// ============================================================================
package sirm_pkg;

    // Fragment count field width and default saturation limit
    localparam int CNT_W                 = 7;
    localparam int MAX_FRAGMENTS_DEFAULT = 64;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input item: one per-fragment reference
    typedef struct packed {
        logic [31:0]      fragment_bytes;
        logic [31:0]      fragment_duration;
        logic [63:0]      fragment_start_time;
        logic [2:0]       access_point_kind;
        logic [31:0]      access_point_offset;
        logic [CNT_W-1:0] fragments_in_segment;
    } frag_t;

    // Result item: one merged subsegment reference
    typedef struct packed {
        logic [31:0] merged_bytes;
        logic [31:0] merged_duration;
        logic [63:0] merged_start_time;
        logic [2:0]  merged_point_kind;
        logic [31:0] merged_point_offset;
        logic        last_of_segment;
    } merged_t;

    // Classification the front attaches to each item
    typedef struct packed {
        logic start_group;  // item opens a new group
        logic emit;         // item closes its group
        logic last;         // item is the segment's last fragment
    } ctrl_t;

    // Queue entry: classified item
    typedef struct packed {
        ctrl_t       ctrl;
        logic [31:0] bytes;
        logic [31:0] duration;
        logic [63:0] start_time;
        logic [2:0]  kind;
        logic [31:0] offset;
    } entry_t;

endpackage

>>> hw/rtl/segment_index_reference_merger.sv
// ============================================================================
// Segment index reference merger - top level
// Merges per-fragment segment index references into subsegment references.
// ============================================================================
// One item in is one fragment reference of a media segment; on the first item
// of a segment the block latches the fragment count and the subsegment setting
// and derives the group size with a restoring divider. The front takes no new
// item until the held one is classified and queued, nor, on a segment's first
// item with merging on, before the divider is done. A merged reference is
// loaded into the output register once the item closing its group has left
// the queue and that register is free. The cfg_wr_data setting is used on the
// first item of each segment; write it only while the block is idle.

module segment_index_reference_merger #(
    parameter int MAX_FRAGMENTS = sirm_pkg::MAX_FRAGMENTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frag_valid,
    output logic               frag_stall,
    input  sirm_pkg::frag_t    frag_item,
    output logic               merge_valid,
    input  logic               merge_stall,
    output sirm_pkg::merged_t  merge_item,
    input  logic               cfg_wr_en,
    input  logic signed [7:0]  cfg_wr_data
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_avail;
    sirm_pkg::entry_t q_in;
    sirm_pkg::entry_t q_out;

    // Front: accept and classify
    sirm_front #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .frag_valid  (frag_valid),
        .frag_stall  (frag_stall),
        .frag_item   (frag_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_push      (q_push),
        .q_entry     (q_in),
        .q_full      (q_full)
    );

    // Queue between front and back
    sirm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .avail      (q_avail)
    );

    // Back: accumulate and deliver
    sirm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_entry     (q_out),
        .q_avail     (q_avail),
        .q_pop       (q_pop),
        .merge_valid (merge_valid),
        .merge_stall (merge_stall),
        .merge_item  (merge_item)
    );

endmodule

>>> hw/rtl/sirm_div.sv
// ============================================================================
// Segment index reference merger - group size divider
// Restoring divider, one quotient bit per cycle.
// ============================================================================
`include "segment_index_reference_merger_defines.svh"

module sirm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sirm_pkg::CNT_W-1:0] dividend,
    input  logic [sirm_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [sirm_pkg::CNT_W-1:0] quotient
);

    localparam int W      = sirm_pkg::CNT_W;
    localparam int STEP_W = $clog2(W);

    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      quo_reg, quo_next;
    logic [W-1:0]      div_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [W:0]        trial;
    logic              fits;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[W-1]};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? W'(trial - {1'b0, div_reg}) : trial[W-1:0];
        quo_next = {quo_reg[W-2:0], fits};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `SIRM_ASSERT_NEXT(a_div_done_after_busy, clk, rst_n, busy_reg && step_reg == STEP_W'(W - 1) && !start, done_reg)

endmodule

>>> hw/rtl/sirm_front.sv
// ============================================================================
// Segment index reference merger - front end
// Accepts fragment items, sizes groups and classifies each item.
// ============================================================================
`include "segment_index_reference_merger_defines.svh"

module sirm_front #(
    parameter int MAX_FRAGMENTS = sirm_pkg::MAX_FRAGMENTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frag_valid,
    output logic              frag_stall,
    input  sirm_pkg::frag_t   frag_item,
    input  logic              cfg_wr_en,
    input  logic signed [7:0] cfg_wr_data,
    output logic              q_push,
    output sirm_pkg::entry_t  q_entry,
    input  logic              q_full
);

    localparam int W = sirm_pkg::CNT_W;

    typedef enum logic [1:0] {S_TAKE, S_DIVIDE, S_PUSH} state_t;

    state_t            state_reg;
    logic signed [7:0] subseg_reg;
    sirm_pkg::frag_t   item_reg;
    logic [W-1:0]      seen_reg;
    logic [W-1:0]      total_reg;
    logic [W-1:0]      group_size_reg;
    logic [W-1:0]      cig_reg;
    logic              last_reg;

    logic              take;
    logic              first;
    logic              merge_on;
    logic [W-1:0]      cnt_sat;
    logic [W-1:0]      total_now;
    logic [W:0]        seen_inc;
    logic              last_now;
    logic [W:0]        cig_inc;
    logic              pass;
    sirm_pkg::ctrl_t   ctrl;
    logic              div_start;
    logic              div_done;
    logic [W-1:0]      div_quo;

    assign frag_stall = (state_reg != S_TAKE);
    assign take       = frag_valid && !frag_stall;
    assign first      = (seen_reg == '0);
    assign merge_on   = (subseg_reg > 8'sd0);

    // Fragment count clamp: zero reads as one, large counts saturate
    always_comb
    begin
        if (frag_item.fragments_in_segment == '0)
            cnt_sat = W'(1);
        else if (32'(frag_item.fragments_in_segment) > MAX_FRAGMENTS)
            cnt_sat = W'(MAX_FRAGMENTS);
        else
            cnt_sat = frag_item.fragments_in_segment;
    end

    // Segment position of the incoming item
    assign total_now = first ? cnt_sat : total_reg;
    assign seen_inc  = {1'b0, seen_reg} + 1'b1;
    assign last_now  = seen_inc >= {1'b0, total_now};

    // Group size = (count - 1) / subsegments + 1
    assign div_start = take && first && merge_on;

    sirm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cnt_sat - 1'b1),
        .divisor  (subseg_reg[W-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Classify the held item
    always_comb
    begin
        cig_inc          = {1'b0, cig_reg} + 1'b1;
        pass             = (group_size_reg <= W'(1));
        ctrl.start_group = pass || (cig_reg == '0);
        ctrl.emit        = pass || last_reg || (cig_inc >= {1'b0, group_size_reg});
        ctrl.last        = last_reg;
    end

    assign q_push              = (state_reg == S_PUSH) && !q_full;
    assign q_entry.ctrl        = ctrl;
    assign q_entry.bytes       = item_reg.fragment_bytes;
    assign q_entry.duration    = item_reg.fragment_duration;
    assign q_entry.start_time  = item_reg.fragment_start_time;
    assign q_entry.kind        = item_reg.access_point_kind;
    assign q_entry.offset      = item_reg.access_point_offset;

    // State and segment counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_TAKE;
            subseg_reg     <= '0;
            seen_reg       <= '0;
            total_reg      <= '0;
            group_size_reg <= '0;
            cig_reg        <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                subseg_reg <= cfg_wr_data;
            unique case (state_reg)
                S_TAKE:
                begin
                    if (take)
                    begin
                        seen_reg <= last_now ? '0 : seen_inc[W-1:0];
                        last_reg <= last_now;
                        if (first)
                        begin
                            total_reg <= cnt_sat;
                            cig_reg   <= '0;
                            if (merge_on)
                                state_reg <= S_DIVIDE;
                            else
                            begin
                                group_size_reg <= W'(1);
                                state_reg      <= S_PUSH;
                            end
                        end
                        else
                            state_reg <= S_PUSH;
                    end
                end
                S_DIVIDE:
                begin
                    if (div_done)
                    begin
                        group_size_reg <= div_quo + 1'b1;
                        state_reg      <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (q_push)
                    begin
                        cig_reg   <= ctrl.emit ? '0 : cig_inc[W-1:0];
                        state_reg <= S_TAKE;
                    end
                end
                default:
                    state_reg <= S_TAKE;
            endcase
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= frag_item;
    end

    `SIRM_ASSERT_IMPLY(a_front_group_sized, clk, rst_n, state_reg == S_PUSH, group_size_reg != '0)
    `SIRM_ASSERT_IMPLY(a_front_seen_bound, clk, rst_n, state_reg == S_TAKE && seen_reg != '0, seen_reg < total_reg)

endmodule

>>> hw/rtl/sirm_fifo.sv
// ============================================================================
// Segment index reference merger - item queue
// Short queue of classified items between front and back.
// ============================================================================
`include "segment_index_reference_merger_defines.svh"

module sirm_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sirm_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output sirm_pkg::entry_t pop_entry,
    output logic             avail
);

    localparam int DEPTH = sirm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sirm_pkg::entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign avail     = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    `SIRM_ASSERT_IMPLY(a_fifo_no_overflow, clk, rst_n, push, !full || pop)
    `SIRM_ASSERT_IMPLY(a_fifo_no_underflow, clk, rst_n, pop, avail)

endmodule

>>> hw/rtl/sirm_back.sv
// ============================================================================
// Segment index reference merger - back end
// Accumulates groups and delivers merged references.
// ============================================================================
`include "segment_index_reference_merger_defines.svh"

module sirm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sirm_pkg::entry_t   q_entry,
    input  logic               q_avail,
    output logic               q_pop,
    output logic               merge_valid,
    input  logic               merge_stall,
    output sirm_pkg::merged_t  merge_item
);

    // Group accumulators
    logic [31:0]       sum_bytes_reg;
    logic [31:0]       sum_dur_reg;
    logic [63:0]       min_start_reg;
    logic [2:0]        held_kind_reg;
    logic [31:0]       point_time_reg;  // low half of first SAP time
    logic [31:0]       lead_off_reg;
    logic              last_reg;
    logic              pending_reg;

    sirm_pkg::merged_t out_reg;
    logic              out_valid_reg;

    logic              load_out;
    logic [31:0]       res_off;

    // A finished group moves out when the output register is free
    assign load_out = pending_reg && (!out_valid_reg || !merge_stall);
    assign q_pop    = q_avail && (!pending_reg || load_out);

    assign res_off = (held_kind_reg != '0) ? (point_time_reg - min_start_reg[31:0])
                                           : lead_off_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                pending_reg <= q_entry.ctrl.emit;
            else if (load_out)
                pending_reg <= 1'b0;

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!merge_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Accumulation and output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.merged_bytes        <= sum_bytes_reg;
            out_reg.merged_duration     <= sum_dur_reg;
            out_reg.merged_start_time   <= min_start_reg;
            out_reg.merged_point_kind   <= held_kind_reg;
            out_reg.merged_point_offset <= res_off;
            out_reg.last_of_segment     <= last_reg;
        end
        if (q_pop)
        begin
            last_reg <= q_entry.ctrl.last;
            if (q_entry.ctrl.start_group)
            begin
                sum_bytes_reg  <= q_entry.bytes;
                sum_dur_reg    <= q_entry.duration;
                min_start_reg  <= q_entry.start_time;
                held_kind_reg  <= q_entry.kind;
                lead_off_reg   <= q_entry.offset;
                point_time_reg <= q_entry.offset + q_entry.start_time[31:0];
            end
            else
            begin
                sum_bytes_reg <= sum_bytes_reg + q_entry.bytes;
                sum_dur_reg   <= sum_dur_reg + q_entry.duration;
                if (q_entry.start_time < min_start_reg)
                    min_start_reg <= q_entry.start_time;
                // first known SAP type wins
                if (held_kind_reg == '0 && q_entry.kind != '0)
                begin
                    held_kind_reg  <= q_entry.kind;
                    point_time_reg <= q_entry.offset + q_entry.start_time[31:0];
                end
            end
        end
    end

    assign merge_valid = out_valid_reg;
    assign merge_item  = out_reg;

    `SIRM_ASSERT_NEXT(a_back_pending_drains, clk, rst_n, pending_reg && !out_valid_reg, out_valid_reg)

endmodule
